FILE: sv/blc_pkg.sv
// Shared constants, types and helpers of the binary line centroid block.
`default_nettype none

package blc_pkg;

  // Image geometry limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);

  // Set-pixel counters saturate at all ones
  localparam int RCNT_W = 11;
  localparam int FCNT_W = 21;
  localparam logic [RCNT_W-1:0] ROW_CNT_CAP   = {RCNT_W{1'b1}};
  localparam logic [FCNT_W-1:0] FRAME_CNT_CAP = {FCNT_W{1'b1}};

  // Sums sized so they never wrap at the count caps
  localparam int RSUM_W  = RCNT_W + COL_W;
  localparam int FCSUM_W = FCNT_W + COL_W;
  localparam int FRSUM_W = FCNT_W + ROW_W;

  // Divider operand widths
  localparam int DVD_W0  = (RSUM_W > FCSUM_W) ? RSUM_W : FCSUM_W;
  localparam int DVD_W   = (DVD_W0 > FRSUM_W) ? DVD_W0 : FRSUM_W;
  localparam int DVS_W   = FCNT_W;
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  // Pixel, threshold and result widths
  localparam int PIX_W = 8;
  localparam int OUT_W = 10;
  localparam logic [PIX_W-1:0] THR_RESET = 8'd128;

  // Result kinds
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Divider operand selection
  localparam logic [1:0] DSEL_ROW  = 2'd0;
  localparam logic [1:0] DSEL_FCOL = 2'd1;
  localparam logic [1:0] DSEL_FROW = 2'd2;

  typedef struct packed {
    logic       acc;        // take one pixel into the accumulators
    logic       div_start;  // launch a division
    logic [1:0] div_sel;    // operands of that division
    logic       save_fcol;  // keep the frame column mean
    logic       put_row;    // load a row result
    logic       put_frame;  // load the frame result
    logic       finish;     // close the row (and frame)
  } ctrl_cmd_t;

  typedef struct packed {
    logic rend;      // held item closes a row
    logic fend;      // held item closes the frame
    logic row_nz;    // row has set pixels
    logic frame_nz;  // frame has set pixels
    logic div_done;  // quotient ready
    logic out_free;  // result register can take a value
  } dp_status_t;

  // Saturate a wide mean to the result width
  function automatic logic [OUT_W-1:0] clamp_out(input logic [DVD_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > DVD_W'({OUT_W{1'b1}})) begin
      r = {OUT_W{1'b1}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/blc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module blc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [blc_pkg::DVD_W-1:0]  dividend,
  input  wire logic [blc_pkg::DVS_W-1:0]  divisor,
  output logic                            busy,
  output logic                            done,
  output logic [blc_pkg::DVD_W-1:0]       quotient
);

  logic [blc_pkg::DVD_W-1:0]  q_r,    q_nxt;
  logic [blc_pkg::DVS_W:0]    rem_r,  rem_nxt;
  logic [blc_pkg::DVS_W-1:0]  dvs_r,  dvs_nxt;
  logic [blc_pkg::DCNT_W-1:0] cnt_r,  cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [blc_pkg::DVS_W:0]    shifted;
  logic [blc_pkg::DVS_W+1:0]  diff;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem_r[blc_pkg::DVS_W-1:0], q_r[blc_pkg::DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = blc_pkg::DCNT_W'(blc_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift in one dividend bit, keep the difference when no borrow
      if (diff[blc_pkg::DVS_W+1]) begin
        rem_nxt = shifted;
        q_nxt   = {q_r[blc_pkg::DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[blc_pkg::DVS_W:0];
        q_nxt   = {q_r[blc_pkg::DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - blc_pkg::DCNT_W'(1);
      if (cnt_r == blc_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

FILE: sv/blc_ctrl.sv
// Controller state machine: sequences accumulation, divisions and results.
`default_nettype none

module blc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire blc_pkg::dp_status_t sts,
  output blc_pkg::ctrl_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ROW_CHK = 4'd1;
  localparam logic [3:0] S_ROW_DIV = 4'd2;
  localparam logic [3:0] S_ROW_PUT = 4'd3;
  localparam logic [3:0] S_FRM_CHK = 4'd4;
  localparam logic [3:0] S_FC_DIV  = 4'd5;
  localparam logic [3:0] S_FR_DIV  = 4'd6;
  localparam logic [3:0] S_FRM_PUT = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = blc_pkg::DSEL_ROW;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // Plain pixels stream at one per cycle; hold input once a row end is taken
        if (sts.rend) begin
          state_nxt = S_ROW_CHK;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.acc = 1'b1;
          end
        end
      end
      S_ROW_CHK: begin
        if (sts.row_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = blc_pkg::DSEL_ROW;
          state_nxt     = S_ROW_DIV;
        end else begin
          state_nxt = S_FRM_CHK;
        end
      end
      S_ROW_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_ROW_PUT;
        end
      end
      S_ROW_PUT: begin
        if (sts.out_free) begin
          cmd.put_row = 1'b1;
          state_nxt   = S_FRM_CHK;
        end
      end
      S_FRM_CHK: begin
        if (!sts.fend) begin
          state_nxt = S_FIN;
        end else if (sts.frame_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = blc_pkg::DSEL_FCOL;
          state_nxt     = S_FC_DIV;
        end else begin
          state_nxt = S_FRM_PUT;
        end
      end
      S_FC_DIV: begin
        // Keep the column mean and go straight on to the row mean
        if (sts.div_done) begin
          cmd.save_fcol = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = blc_pkg::DSEL_FROW;
          state_nxt     = S_FR_DIV;
        end
      end
      S_FR_DIV: begin
        cmd.div_sel = blc_pkg::DSEL_FROW;
        if (sts.div_done) begin
          state_nxt = S_FRM_PUT;
        end
      end
      S_FRM_PUT: begin
        if (sts.out_free) begin
          cmd.put_frame = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/blc_dp.sv
// Datapath: threshold, accumulators, divider and result register.
`default_nettype none

module blc_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [blc_pkg::PIX_W-1:0]  cfg_wr_data,
  input  wire logic [blc_pkg::PIX_W-1:0]  in_pixel_value,
  input  wire logic                       in_row_end,
  input  wire logic                       in_frame_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_result_kind,
  output logic [blc_pkg::OUT_W-1:0]       out_center_col,
  output logic [blc_pkg::OUT_W-1:0]       out_center_row,
  output logic                            out_last_of_run,
  input  wire blc_pkg::ctrl_cmd_t         cmd,
  output blc_pkg::dp_status_t             sts
);

  logic [blc_pkg::PIX_W-1:0]   thr_r,   thr_nxt;
  logic [blc_pkg::COL_W-1:0]   col_r,   col_nxt;
  logic [blc_pkg::ROW_W-1:0]   row_r,   row_nxt;
  logic [blc_pkg::RSUM_W-1:0]  rsum_r,  rsum_nxt;
  logic [blc_pkg::RCNT_W-1:0]  rcnt_r,  rcnt_nxt;
  logic [blc_pkg::FCSUM_W-1:0] fcsum_r, fcsum_nxt;
  logic [blc_pkg::FRSUM_W-1:0] frsum_r, frsum_nxt;
  logic [blc_pkg::FCNT_W-1:0]  fcnt_r,  fcnt_nxt;
  logic                        rend_r,  rend_nxt;
  logic                        fend_r,  fend_nxt;
  logic [blc_pkg::OUT_W-1:0]   fcol_r,  fcol_nxt;

  logic                        ov_r,    ov_nxt;
  logic                        okind_r, okind_nxt;
  logic [blc_pkg::OUT_W-1:0]   ocol_r,  ocol_nxt;
  logic [blc_pkg::OUT_W-1:0]   orow_r,  orow_nxt;
  logic                        olast_r, olast_nxt;

  logic                        pix_set;
  logic                        rend_in;
  logic [blc_pkg::DVD_W-1:0]   div_dvd;
  logic [blc_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_busy;
  logic                        div_done;
  logic [blc_pkg::DVD_W-1:0]   div_q;

  assign pix_set = (in_pixel_value <= thr_r);
  assign rend_in = in_row_end | in_frame_end;

  // Select divider operands
  always_comb begin
    case (cmd.div_sel)
      blc_pkg::DSEL_FCOL: begin
        div_dvd = blc_pkg::DVD_W'(fcsum_r);
        div_dvs = fcnt_r;
      end
      blc_pkg::DSEL_FROW: begin
        div_dvd = blc_pkg::DVD_W'(frsum_r);
        div_dvs = fcnt_r;
      end
      default: begin
        div_dvd = blc_pkg::DVD_W'(rsum_r);
        div_dvs = blc_pkg::DVS_W'(rcnt_r);
      end
    endcase
  end

  blc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Accumulate pixels and close rows and frames
  always_comb begin
    thr_nxt   = thr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rsum_nxt  = rsum_r;
    rcnt_nxt  = rcnt_r;
    fcsum_nxt = fcsum_r;
    frsum_nxt = frsum_r;
    fcnt_nxt  = fcnt_r;
    rend_nxt  = rend_r;
    fend_nxt  = fend_r;
    fcol_nxt  = fcol_r;
    if (cfg_wr_en) begin
      thr_nxt = cfg_wr_data;
    end
    if (cmd.acc) begin
      rend_nxt = rend_in;
      fend_nxt = in_frame_end;
      if (pix_set && (rcnt_r != blc_pkg::ROW_CNT_CAP)) begin
        rcnt_nxt = rcnt_r + blc_pkg::RCNT_W'(1);
        rsum_nxt = rsum_r + blc_pkg::RSUM_W'(col_r);
      end
      if (pix_set && (fcnt_r != blc_pkg::FRAME_CNT_CAP)) begin
        fcnt_nxt  = fcnt_r + blc_pkg::FCNT_W'(1);
        fcsum_nxt = fcsum_r + blc_pkg::FCSUM_W'(col_r);
        frsum_nxt = frsum_r + blc_pkg::FRSUM_W'(row_r);
      end
      if (!rend_in && (col_r != blc_pkg::COL_W'(blc_pkg::MAX_COLS - 1))) begin
        col_nxt = col_r + blc_pkg::COL_W'(1);
      end
    end
    if (cmd.save_fcol) begin
      fcol_nxt = blc_pkg::clamp_out(div_q);
    end
    if (cmd.finish) begin
      rend_nxt = 1'b0;
      fend_nxt = 1'b0;
      rsum_nxt = '0;
      rcnt_nxt = '0;
      col_nxt  = '0;
      if (fend_r) begin
        row_nxt   = '0;
        fcsum_nxt = '0;
        frsum_nxt = '0;
        fcnt_nxt  = '0;
      end else if (row_r != blc_pkg::ROW_W'(blc_pkg::MAX_ROWS - 1)) begin
        row_nxt = row_r + blc_pkg::ROW_W'(1);
      end
    end
  end

  // Result register: load on a put, drop when taken
  always_comb begin
    ov_nxt    = ov_r;
    okind_nxt = okind_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    olast_nxt = olast_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.put_row) begin
      ov_nxt    = 1'b1;
      okind_nxt = blc_pkg::KIND_ROW;
      ocol_nxt  = blc_pkg::clamp_out(div_q);
      orow_nxt  = blc_pkg::clamp_out(blc_pkg::DVD_W'(row_r));
      olast_nxt = ~fend_r;
    end else if (cmd.put_frame) begin
      ov_nxt    = 1'b1;
      okind_nxt = blc_pkg::KIND_FRAME;
      olast_nxt = 1'b1;
      if (fcnt_r != '0) begin
        ocol_nxt = fcol_r;
        orow_nxt = blc_pkg::clamp_out(div_q);
      end else begin
        ocol_nxt = '0;
        orow_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fcol_r  <= fcol_nxt;
    okind_r <= okind_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      thr_r   <= blc_pkg::THR_RESET;
      col_r   <= '0;
      row_r   <= '0;
      rsum_r  <= '0;
      rcnt_r  <= '0;
      fcsum_r <= '0;
      frsum_r <= '0;
      fcnt_r  <= '0;
      rend_r  <= 1'b0;
      fend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      thr_r   <= thr_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rsum_r  <= rsum_nxt;
      rcnt_r  <= rcnt_nxt;
      fcsum_r <= fcsum_nxt;
      frsum_r <= frsum_nxt;
      fcnt_r  <= fcnt_nxt;
      rend_r  <= rend_nxt;
      fend_r  <= fend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign sts.rend     = rend_r;
  assign sts.fend     = fend_r;
  assign sts.row_nz   = (rcnt_r != '0);
  assign sts.frame_nz = (fcnt_r != '0);
  assign sts.div_done = div_done;
  assign sts.out_free = ~ov_r | out_ready;

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_center_col  = ocol_r;
  assign out_center_row  = orow_r;
  assign out_last_of_run = olast_r;

  // A result never overwrites one that is still waiting
  a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_row || cmd.put_frame) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Row results come only from rows with set pixels
  a_row_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_row |-> (rcnt_r != '0))
    else $error("row result for an empty row");

  // Frame result only after a frame end
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_frame |-> fend_r)
    else $error("frame result without frame end");

  // Quotient ready only at the end of a running division
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> $past(div_busy))
    else $error("divider done without a division");

  // No new pixel taken while a row end is still open
  a_no_acc_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> !rend_r)
    else $error("pixel taken during row end processing");

endmodule

`default_nettype wire

FILE: sv/binary_line_centroid_top.sv
// Top level: thresholded pixel stream to row and frame centroids.
// Pixels that do not end a row are taken at one per cycle.
// A row end blocks input while the row is closed: a row with set pixels first
// runs a division for its result; a frame end with set pixels adds two divisions.
// A finished result sits in the output register while the next pixel is taken.
// rst_n is synchronous, active low: indices and sums clear, threshold is 128.
`default_nettype none

module binary_line_centroid_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [blc_pkg::PIX_W-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [blc_pkg::PIX_W-1:0]  in_pixel_value,
  input  wire logic                       in_row_end,
  input  wire logic                       in_frame_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_result_kind,
  output logic [blc_pkg::OUT_W-1:0]       out_center_col,
  output logic [blc_pkg::OUT_W-1:0]       out_center_row,
  output logic                            out_last_of_run
);

  blc_pkg::ctrl_cmd_t  cmd;
  blc_pkg::dp_status_t sts;

  blc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  blc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_pixel_value  (in_pixel_value),
    .in_row_end      (in_row_end),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_center_col  (out_center_col),
    .out_center_row  (out_center_row),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
